/* hdl/abmm_pkg.sv */
// ---------------------------------------------------------------------------
// abmm_pkg
// Shared types and constants for the batch min/max/average block
// ---------------------------------------------------------------------------
`default_nettype none
package abmm_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int MAX_BATCH   = 255;
   localparam int CNT_W       = 8;
   localparam int SUM_W       = 20;
   localparam int CAL_W       = 12;
   localparam int SLOPE_W     = 16;
   localparam int MV_W        = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // product of calibrated count and slope, also the divider dividend
   localparam int DIVD_W      = CAL_W + SLOPE_W;
   localparam int DIVS_W      = SLOPE_W;
   localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);

   localparam logic [CAL_W-1:0]   BASE_OFFSET_RST = CAL_W'(6);
   localparam logic [SLOPE_W-1:0] SLOPE_NUM_RST   = SLOPE_W'(12341);
   localparam logic [SLOPE_W-1:0] SLOPE_DEN_RST   = SLOPE_W'(10000);

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFFSET = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_NUM   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_DEN   = CSR_IDX_W'(2);

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      JOB_MIN,
      JOB_MAX,
      JOB_AVG
   } job_type;

   typedef struct packed {
      logic    stat_en;
      logic    div_start;
      logic    div_avg;
      logic    avg_cap;
      logic    mul_en;
      logic    mv_cap;
      logic    out_load;
      job_type job;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic rsp_free;
   } status_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] min_count;
      logic [SAMPLE_BITS-1:0] max_count;
      logic [SAMPLE_BITS-1:0] avg_count;
      logic [MV_W-1:0]        min_millivolts;
      logic [MV_W-1:0]        max_millivolts;
      logic [MV_W-1:0]        avg_millivolts;
      logic                   batch_overflow;
   } rsp_data_type;

endpackage
`default_nettype wire

/* hdl/abmm_req_if.sv */
// ---------------------------------------------------------------------------
// abmm_req_if
// Sample channel: one converter reading with its last-of-batch mark
// ---------------------------------------------------------------------------
`default_nettype none
interface abmm_req_if
   import abmm_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

/* hdl/abmm_rsp_if.sv */
// ---------------------------------------------------------------------------
// abmm_rsp_if
// Result channel: batch statistics in counts and millivolts
// ---------------------------------------------------------------------------
`default_nettype none
interface abmm_rsp_if
   import abmm_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] min_count;
   logic [SAMPLE_BITS-1:0] max_count;
   logic [SAMPLE_BITS-1:0] avg_count;
   logic [MV_W-1:0]        min_millivolts;
   logic [MV_W-1:0]        max_millivolts;
   logic [MV_W-1:0]        avg_millivolts;
   logic                   batch_overflow;

   modport source (output valid, output min_count, output max_count, output avg_count,
                   output min_millivolts, output max_millivolts, output avg_millivolts,
                   output batch_overflow, input ready);
   modport sink   (input valid, input min_count, input max_count, input avg_count,
                   input min_millivolts, input max_millivolts, input avg_millivolts,
                   input batch_overflow, output ready);
endinterface
`default_nettype wire

/* hdl/abmm_div.sv */
// ---------------------------------------------------------------------------
// abmm_div
// Restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module abmm_div
   import abmm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [DIVS_W-1:0] divisor,
   output logic                   busy,
   output logic [DIVD_W-1:0]      quotient
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [DIVS_W-1:0]    rem_ff, rem_in;
   logic [DIVS_W-1:0]    dvs_ff, dvs_in;
   logic [DIVS_W:0]      trial;
   logic [DIVS_W:0]      diff;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIVD_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         // a zero divisor always fits, leaving an all-ones quotient
         rem_in = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* hdl/abmm_dpath.sv */
// ---------------------------------------------------------------------------
// abmm_dpath
// Running statistics, calibration registers, multiply/divide and result register
// ---------------------------------------------------------------------------
`default_nettype none
module abmm_dpath
   import abmm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_data_type                rsp_data
);

   logic [CAL_W-1:0]       offset_ff;
   logic [SLOPE_W-1:0]     num_ff;
   logic [SLOPE_W-1:0]     den_ff;

   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   ovf_ff, ovf_in;

   logic [SAMPLE_BITS-1:0] avg_ff;
   logic [MV_W-1:0]        min_mv_ff, max_mv_ff, avg_mv_ff;
   logic [DIVD_W-1:0]      prod_ff;
   logic                   zero_ff;

   logic                   rsp_valid_ff;
   rsp_data_type           rsp_data_ff;

   logic [SAMPLE_BITS-1:0] mul_src;
   logic                   at_offset;
   logic [CAL_W-1:0]       cal_diff;
   logic [DIVD_W-1:0]      dividend;
   logic [DIVS_W-1:0]      divisor;
   logic [DIVD_W-1:0]      quotient;
   logic                   div_busy;
   logic [MV_W-1:0]        mv_val;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= BASE_OFFSET_RST;
         num_ff    <= SLOPE_NUM_RST;
         den_ff    <= SLOPE_DEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_OFFSET: offset_ff <= csr_wdata[CAL_W-1:0];
            CSR_SLOPE_NUM:   num_ff    <= csr_wdata[SLOPE_W-1:0];
            CSR_SLOPE_DEN:   den_ff    <= csr_wdata[SLOPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // running statistics
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.out_load) begin
         min_in = '0;
         max_in = '0;
         sum_in = '0;
         cnt_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.stat_en) begin
         if (cnt_ff < CNT_W'(MAX_BATCH)) begin
            if (cnt_ff == '0) begin
               min_in = sample;
               max_in = sample;
            end else begin
               if (sample < min_ff) min_in = sample;
               if (sample > max_ff) max_in = sample;
            end
            sum_in = sum_ff + SUM_W'(sample);
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   // calibration multiply
   always_comb begin
      unique case (cmd.job)
         JOB_MIN: mul_src = min_ff;
         JOB_MAX: mul_src = max_ff;
         JOB_AVG: mul_src = avg_ff;
         default: mul_src = avg_ff;
      endcase
      at_offset = SAMPLE_BITS'(mul_src) <= SAMPLE_BITS'(offset_ff);
      cal_diff  = CAL_W'(mul_src) - offset_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= DIVD_W'(cal_diff) * DIVD_W'(den_ff);
         zero_ff <= at_offset;
      end
   end

   // shared divider: mean first, then the three millivolt values
   assign dividend = cmd.div_avg ? DIVD_W'(sum_ff) : prod_ff;
   assign divisor  = cmd.div_avg ? DIVS_W'(cnt_ff) : num_ff;

   abmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // zero at or below the offset, else saturate at full scale
   always_comb begin
      if (zero_ff) begin
         mv_val = '0;
      end else if (quotient[DIVD_W-1:MV_W] != '0) begin
         mv_val = '1;
      end else begin
         mv_val = quotient[MV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.avg_cap) begin
         avg_ff <= quotient[SAMPLE_BITS-1:0];
      end
      if (cmd.mv_cap) begin
         unique case (cmd.job)
            JOB_MIN: min_mv_ff <= mv_val;
            JOB_MAX: max_mv_ff <= mv_val;
            JOB_AVG: avg_mv_ff <= mv_val;
            default: avg_mv_ff <= mv_val;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.min_count      <= min_ff;
         rsp_data_ff.max_count      <= max_ff;
         rsp_data_ff.avg_count      <= avg_ff;
         rsp_data_ff.min_millivolts <= min_mv_ff;
         rsp_data_ff.max_millivolts <= max_mv_ff;
         rsp_data_ff.avg_millivolts <= avg_mv_ff;
         rsp_data_ff.batch_overflow <= ovf_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.div_busy = div_busy;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

/* hdl/abmm_ctrl.sv */
// ---------------------------------------------------------------------------
// abmm_ctrl
// Sequencer: collects samples, then runs the mean and calibration steps
// ---------------------------------------------------------------------------
`default_nettype none
module abmm_ctrl
   import abmm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         job_ff   <= JOB_MIN;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      req_ready     = 1'b0;
      accept        = 1'b0;
      cmd           = '0;
      cmd.job       = job_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready   = 1'b1;
            accept      = req_valid;
            cmd.stat_en = accept;
            if (accept && req_last) begin
               state_in = ST_AVG_START;
            end
         end
         ST_AVG_START: begin
            cmd.div_start = 1'b1;
            cmd.div_avg   = 1'b1;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (!status.div_busy) begin
               cmd.avg_cap = 1'b1;
               job_in      = JOB_MIN;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               cmd.mv_cap = 1'b1;
               unique case (job_ff)
                  JOB_MIN: begin
                     job_in   = JOB_MAX;
                     state_in = ST_MUL;
                  end
                  JOB_MAX: begin
                     job_in   = JOB_AVG;
                     state_in = ST_MUL;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            // hold until the result register can take a new beat
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hdl/adc_batch_min_max_avg_mv.sv */
// ---------------------------------------------------------------------------
// adc_batch_min_max_avg_mv
// Batch minimum, maximum and mean of converter samples with mV calibration
// ---------------------------------------------------------------------------
// req_ch carries one 12-bit sample per beat plus a last mark. Samples that
// do not close a batch are taken one per cycle and only update the running
// min, max, sum and count. Beats past 255 in one batch are dropped and
// flag batch_overflow.
// The beat with last set starts the closing sequence: the mean is worked out
// on a radix-2 divider, then each of min, max and mean is offset, multiplied
// by slope_denominator and divided by slope_numerator on the same divider.
// One rsp_ch beat follows each batch; req_ch.ready is low from the last
// sample until the sequence has loaded the result register.
// rsp_ch is a registered output: a waiting result does not block the next
// batch, but a second closing sample holds in its final step until the
// first result beat has been taken.
// csr_we/csr_index/csr_wdata write base_offset (0), slope_numerator (1) and
// slope_denominator (2); write only while idle.
// Reset (synchronous) restores calibration defaults and clears the batch.
// ---------------------------------------------------------------------------
`default_nettype none
module adc_batch_min_max_avg_mv
   import abmm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   abmm_req_if.sink                   req_ch,
   abmm_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type      cmd;
   status_type   status;
   rsp_data_type rsp_data;
   logic         req_ready;
   logic         rsp_valid;

   abmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   abmm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .sample    (req_ch.sample),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_data)
   );

   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.min_count      = rsp_data.min_count;
   assign rsp_ch.max_count      = rsp_data.max_count;
   assign rsp_ch.avg_count      = rsp_data.avg_count;
   assign rsp_ch.min_millivolts = rsp_data.min_millivolts;
   assign rsp_ch.max_millivolts = rsp_data.max_millivolts;
   assign rsp_ch.avg_millivolts = rsp_data.avg_millivolts;
   assign rsp_ch.batch_overflow = rsp_data.batch_overflow;

endmodule
`default_nettype wire

/* bench/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Batch min/max/mean and millivolt calibration check for the converter block
// ---------------------------------------------------------------------------
// Sample beats are fed from a queue by a clocked driver. Every accepted beat
// also updates a local copy of the batch statistics. A closing beat queues
// the expected result, which the monitor compares with each result beat.
// The calibration registers are reprogrammed between phases while the block
// is idle. Idling on both channels is random, and there is one long receiver
// hold so that the block backs up onto its sample channel.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
   import abmm_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int DRAIN_CYCLES = 160;
   localparam int HOLD_CYCLES  = 700;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 20;
   localparam int MAX_REPORTS  = 10;

   // no register sits at this index, a write must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   last;
   } sample_beat_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   abmm_req_if req_bus ();
   abmm_rsp_if rsp_bus ();

   adc_batch_min_max_avg_mv dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sample_beat_type beats_to_send[$];
   rsp_data_type    stats_due[$];
   rsp_data_type    seen_stats;
   rsp_data_type    due_stats;

   int   send_idle_pct = 21;
   int   recv_idle_pct = 75;
   logic hold_go       = 1'b0;
   logic hold_armed    = 1'b0;
   int   hold_left     = 0;
   int   fault_count   = 0;
   int   cycle_count   = 0;

   // local copy of the calibration and of the open batch
   logic [CAL_W-1:0]       base_offset_q = BASE_OFFSET_RST;
   logic [SLOPE_W-1:0]     slope_num_q   = SLOPE_NUM_RST;
   logic [SLOPE_W-1:0]     slope_den_q   = SLOPE_DEN_RST;
   logic [SAMPLE_BITS-1:0] batch_lo      = '0;
   logic [SAMPLE_BITS-1:0] batch_hi      = '0;
   logic [SUM_W-1:0]       batch_total   = '0;
   logic [CNT_W-1:0]       batch_n       = '0;
   logic                   batch_dropped = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [MV_W-1:0] count_to_mv(input logic [SAMPLE_BITS-1:0] c);
      logic [63:0] span;
      logic [63:0] q;
      if (c <= base_offset_q) begin
         return '0;
      end
      // nothing to divide by: saturate
      if (slope_num_q == '0) begin
         return '1;
      end
      span = c - base_offset_q;
      q = span * slope_den_q / slope_num_q;
      return (q > 64'd65535) ? '1 : q[MV_W-1:0];
   endfunction

   task automatic fold_sample(input sample_beat_type b);
      rsp_data_type           res;
      logic [SAMPLE_BITS-1:0] mean;
      if (batch_n < CNT_W'(MAX_BATCH)) begin
         if (batch_n == '0) begin
            batch_lo = b.sample;
            batch_hi = b.sample;
         end else begin
            if (b.sample < batch_lo) batch_lo = b.sample;
            if (b.sample > batch_hi) batch_hi = b.sample;
         end
         batch_total = batch_total + SUM_W'(b.sample);
         batch_n     = batch_n + 1'b1;
      end else begin
         // batch full, beat dropped
         batch_dropped = 1'b1;
      end
      if (b.last) begin
         mean = (batch_n == '0) ? '0 : SAMPLE_BITS'(batch_total / batch_n);
         res.min_count      = batch_lo;
         res.max_count      = batch_hi;
         res.avg_count      = mean;
         res.min_millivolts = count_to_mv(batch_lo);
         res.max_millivolts = count_to_mv(batch_hi);
         res.avg_millivolts = count_to_mv(mean);
         res.batch_overflow = batch_dropped;
         stats_due.push_back(res);
         batch_lo      = '0;
         batch_hi      = '0;
         batch_total   = '0;
         batch_n       = '0;
         batch_dropped = 1'b0;
      end
   endtask

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid  <= 1'b1;
            req_bus.sample <= beats_to_send[0].sample;
            req_bus.last   <= beats_to_send[0].last;
            void'(beats_to_send.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long receiver hold, counted on its own
   always @(posedge clock) begin
      if (hold_go && !hold_armed) begin
         hold_armed <= 1'b1;
         hold_left  <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: predict on sample beats, check result beats
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            fold_sample('{sample: req_bus.sample, last: req_bus.last});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_stats.min_count      = rsp_bus.min_count;
            seen_stats.max_count      = rsp_bus.max_count;
            seen_stats.avg_count      = rsp_bus.avg_count;
            seen_stats.min_millivolts = rsp_bus.min_millivolts;
            seen_stats.max_millivolts = rsp_bus.max_millivolts;
            seen_stats.avg_millivolts = rsp_bus.avg_millivolts;
            seen_stats.batch_overflow = rsp_bus.batch_overflow;
            if (stats_due.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS) begin
                  $display("unexpected result beat at cycle %0d", cycle_count);
               end
            end else begin
               due_stats = stats_due.pop_front();
               if (seen_stats !== due_stats) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS) begin
                     $display("mismatch at cycle %0d", cycle_count);
                     $display("  expected min %0d max %0d avg %0d mv %0d %0d %0d ovf %0b",
                              due_stats.min_count, due_stats.max_count,
                              due_stats.avg_count, due_stats.min_millivolts,
                              due_stats.max_millivolts, due_stats.avg_millivolts,
                              due_stats.batch_overflow);
                     $display("  actual   min %0d max %0d avg %0d mv %0d %0d %0d ovf %0b",
                              seen_stats.min_count, seen_stats.max_count,
                              seen_stats.avg_count, seen_stats.min_millivolts,
                              seen_stats.max_millivolts, seen_stats.avg_millivolts,
                              seen_stats.batch_overflow);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_BASE_OFFSET: base_offset_q = data[CAL_W-1:0];
         CSR_SLOPE_NUM:   slope_num_q   = data;
         CSR_SLOPE_DEN:   slope_den_q   = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_beat(input logic [SAMPLE_BITS-1:0] s, input logic l);
      beats_to_send.push_back('{sample: s, last: l});
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int v;
      case ($urandom_range(3))
         0: v = $urandom_range(1) ? 4095 : 0;
         // around the offset, where the millivolt map turns on
         1: v = int'(base_offset_q) + int'($urandom_range(3)) - 1;
         default: v = $urandom_range(4095);
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SAMPLE_BITS'(v);
   endfunction

   task automatic queue_batch(input int len);
      for (int i = 0; i < len; i++) begin
         push_beat(pick_sample(), i == len - 1);
      end
   endtask

   // wait for the block to go quiet, sampled away from the active edge
   task automatic wait_idle();
      while (beats_to_send.size() != 0 || req_bus.valid || stats_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int queued;
      int len;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      req_bus.last   = 1'b0;
      rsp_bus.ready  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: extremes, offset edge, mixed batches
      push_beat(12'd0, 1'b1);
      push_beat(12'd4095, 1'b1);
      push_beat(12'd6, 1'b1);
      push_beat(12'd7, 1'b1);
      push_beat(12'hAAA, 1'b0);
      push_beat(12'h555, 1'b1);
      repeat (2) push_beat(12'd4095, 1'b0);
      push_beat(12'd4095, 1'b1);
      push_beat(12'd100, 1'b0);
      push_beat(12'd50, 1'b0);
      push_beat(12'd3000, 1'b0);
      push_beat(12'd50, 1'b1);
      push_beat(12'd0, 1'b0);
      push_beat(12'd4095, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            0: begin
               // upper bits of the offset write fall away
               write_reg(CSR_BASE_OFFSET, 16'hF000);
               write_reg(CSR_SLOPE_NUM, 16'd1);
               write_reg(CSR_SLOPE_DEN, 16'hFFFF);
            end
            1: begin
               write_reg(CSR_BASE_OFFSET, 16'd4095);
               write_reg(CSR_SLOPE_NUM, 16'hFFFF);
               write_reg(CSR_SLOPE_DEN, 16'd1);
            end
            2: begin
               // zero divisor saturates
               write_reg(CSR_BASE_OFFSET, CSR_DATA_W'($urandom_range(200)));
               write_reg(CSR_SLOPE_NUM, 16'd0);
               write_reg(CSR_SLOPE_DEN, CSR_DATA_W'($urandom_range(65535, 1)));
            end
            3: begin
               write_reg(CSR_BASE_OFFSET, CSR_DATA_W'($urandom));
               write_reg(CSR_SLOPE_NUM, CSR_DATA_W'($urandom_range(65535, 1)));
               write_reg(CSR_SLOPE_DEN, CSR_DATA_W'($urandom));
            end
            4: begin
               write_reg(CSR_BASE_OFFSET, 16'd1);
               write_reg(CSR_SLOPE_NUM, 16'hFFFF);
               write_reg(CSR_SLOPE_DEN, 16'hFFFF);
               write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
            end
            default: begin
               write_reg(CSR_BASE_OFFSET, CSR_DATA_W'($urandom_range(63)));
               write_reg(CSR_SLOPE_NUM, CSR_DATA_W'($urandom_range(20000, 1)));
               write_reg(CSR_SLOPE_DEN, CSR_DATA_W'($urandom_range(65535, 1)));
            end
         endcase

         queued = 0;
         while (queued < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            queue_batch(len);
            queued += len;
         end
         // full batch: reaches the limit, then one beat past it
         if (phase == 0) begin
            queue_batch(MAX_BATCH + 1);
         end
         if (phase == 5) begin
            hold_go <= 1'b1;
         end
         wait_idle();
      end

      if (fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* adc_batch_min_max_avg_mv.f */
hdl/abmm_pkg.sv
hdl/abmm_req_if.sv
hdl/abmm_rsp_if.sv
hdl/abmm_div.sv
hdl/abmm_dpath.sv
hdl/abmm_ctrl.sv
hdl/adc_batch_min_max_avg_mv.sv
bench/testbench.sv
